@@ hw/rtl/vdit_pkg.sv @@
// shared constants, slot word type and helpers for the vertex dedup index table
`default_nettype none

package vdit_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int TABLE_SLOTS  = 8192;

    localparam int COORD_W = 32;
    localparam int IDX_W   = 12;
    localparam int SLOT_AW = $clog2(TABLE_SLOTS);
    localparam int COUNT_W = $clog2(MAX_VERTICES + 1);
    localparam int EPOCH_W = 4;

    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    localparam logic [COORD_W-1:0] NEG_ZERO = 32'h8000_0000;
    localparam logic [COORD_W-1:0] HASH_KX  = 32'h9E37_79B1;
    localparam logic [COORD_W-1:0] HASH_KY  = 32'h85EB_CA77;
    localparam logic [COORD_W-1:0] HASH_KZ  = 32'hC2B2_AE3D;

    // one table slot: an entry is live only when its epoch matches the current one
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [IDX_W-1:0]   idx;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    function automatic logic [COORD_W-1:0] fold_zero(input logic [COORD_W-1:0] v);
        fold_zero = (v == NEG_ZERO) ? '0 : v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vdit_in_if.sv @@
// vertex input channel
`default_nettype none

interface vdit_in_if;
    logic                        valid;
    logic                        ready;
    logic [vdit_pkg::COORD_W-1:0] x_bits;
    logic [vdit_pkg::COORD_W-1:0] y_bits;
    logic [vdit_pkg::COORD_W-1:0] z_bits;
    logic                        new_mesh;

    modport source (output valid, output x_bits, output y_bits, output z_bits,
                    output new_mesh, input ready);
    modport sink   (input valid, input x_bits, input y_bits, input z_bits,
                    input new_mesh, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/vdit_out_if.sv @@
// index result channel
`default_nettype none

interface vdit_out_if;
    logic                       valid;
    logic                       ready;
    logic [vdit_pkg::IDX_W-1:0] vertex_index;
    logic                       is_new;
    logic                       table_full;

    modport source (output valid, output vertex_index, output is_new,
                    output table_full, input ready);
    modport sink   (input valid, input vertex_index, input is_new,
                    input table_full, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/vdit_ram.sv @@
// generic single-port ram with registered read
`default_nettype none

module vdit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/vdit_hash.sv @@
// two-step key hash: registered products, then xor fold down to a slot address
`default_nettype none

module vdit_hash (
    input  wire logic                         i_clk,
    input  wire logic [vdit_pkg::COORD_W-1:0] i_x,
    input  wire logic [vdit_pkg::COORD_W-1:0] i_y,
    input  wire logic [vdit_pkg::COORD_W-1:0] i_z,
    output logic      [vdit_pkg::SLOT_AW-1:0] o_slot
);

    logic [vdit_pkg::COORD_W-1:0] n_px, n_py, n_pz;
    logic [vdit_pkg::COORD_W-1:0] r_px, r_py, r_pz;
    logic [vdit_pkg::COORD_W-1:0] w_mix;
    logic [vdit_pkg::COORD_W-1:0] w_fold;

    // low 32 bits of each product only
    assign n_px = i_x * vdit_pkg::HASH_KX;
    assign n_py = i_y * vdit_pkg::HASH_KY;
    assign n_pz = i_z * vdit_pkg::HASH_KZ;

    always_ff @(posedge i_clk) begin
        r_px <= n_px;
        r_py <= n_py;
        r_pz <= n_pz;
    end

    assign w_mix  = r_px ^ r_py ^ r_pz;
    assign w_fold = w_mix ^ (w_mix >> 16);
    assign o_slot = w_fold[vdit_pkg::SLOT_AW-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/vertex_dedup_index_table.sv @@
// Vertex dedup index table. Each input transfer carries one vertex (three float bit patterns,
// negative zero folded to positive zero) and yields one result transfer with its dense index,
// a new flag, or a full flag once 4096 vertices are stored. The table is a linear-probing hash
// in one single-port 8192-slot ram. A vertex passes through S_HASH, S_ADDR and S_PROBE to the result,
// with S_PROBE repeated for each further slot probed; the ram port
// (one slot read per cycle) sets this. Input is taken only while no vertex is in flight; a
// finished result waits in the output register while the next vertex is taken. Slots carry
// an epoch tag so new_mesh clears the table at once; a clearing pass over all 8192 slots runs after
// reset and again on every fifteenth new_mesh, and no input is taken during it.
`default_nettype none

module vertex_dedup_index_table (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vdit_in_if.sink   i_vtx,
    vdit_out_if.source o_res
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_HASH  = 6'b000100,
        S_ADDR  = 6'b001000,
        S_PROBE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    localparam logic [vdit_pkg::SLOT_AW-1:0] SLOT_LAST = vdit_pkg::SLOT_AW'(vdit_pkg::TABLE_SLOTS - 1);
    localparam logic [vdit_pkg::COUNT_W-1:0] COUNT_MAX = vdit_pkg::COUNT_W'(vdit_pkg::MAX_VERTICES);

    t_state r_state, n_state;
    logic [vdit_pkg::EPOCH_W-1:0] r_epoch, n_epoch;
    logic [vdit_pkg::COUNT_W-1:0] r_count, n_count;
    logic [vdit_pkg::SLOT_AW-1:0] r_clr_addr, n_clr_addr;
    logic                         r_have_item, n_have_item;
    logic                         r_out_valid, n_out_valid;

    logic [vdit_pkg::COORD_W-1:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic [vdit_pkg::SLOT_AW-1:0] r_pos, n_pos;
    logic [vdit_pkg::SLOT_AW-1:0] r_probe, n_probe;
    logic [vdit_pkg::IDX_W-1:0]   r_res_idx, n_res_idx, r_out_idx, n_out_idx;
    logic                         r_res_new, n_res_new, r_out_new, n_out_new;
    logic                         r_res_full, n_res_full, r_out_full, n_out_full;

    logic [vdit_pkg::SLOT_AW-1:0] w_hash_slot;
    logic [vdit_pkg::SLOT_AW-1:0] w_next_pos;
    logic                         w_ram_we;
    logic [vdit_pkg::SLOT_AW-1:0] w_ram_addr;
    vdit_pkg::t_slot              w_wslot;
    logic [vdit_pkg::SLOT_W-1:0]  w_rdata;
    vdit_pkg::t_slot              w_rslot;
    logic                         w_live;
    logic                         w_key_eq;
    logic                         w_out_free;
    logic                         w_resolved;
    logic [vdit_pkg::IDX_W-1:0]   w_idx;
    logic                         w_new;
    logic                         w_full;

    vdit_hash u_hash (
        .i_clk  (i_clk),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_z    (r_z),
        .o_slot (w_hash_slot)
    );

    vdit_ram #(
        .WIDTH (vdit_pkg::SLOT_W),
        .DEPTH (vdit_pkg::TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_wslot),
        .o_rdata (w_rdata)
    );

    assign w_rslot    = w_rdata;
    assign w_live     = (w_rslot.epoch == r_epoch);
    assign w_key_eq   = (w_rslot.x == r_x) && (w_rslot.y == r_y) && (w_rslot.z == r_z);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_next_pos = (r_pos == SLOT_LAST) ? '0 : r_pos + 1'b1;

    assign i_vtx.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.vertex_index = r_out_idx;
    assign o_res.is_new       = r_out_new;
    assign o_res.table_full   = r_out_full;

    always_comb begin
        n_state     = r_state;
        n_epoch     = r_epoch;
        n_count     = r_count;
        n_clr_addr  = r_clr_addr;
        n_have_item = r_have_item;
        n_out_valid = r_out_valid && !o_res.ready;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_pos       = r_pos;
        n_probe     = r_probe;
        n_res_idx   = r_res_idx;
        n_res_new   = r_res_new;
        n_res_full  = r_res_full;
        n_out_idx   = r_out_idx;
        n_out_new   = r_out_new;
        n_out_full  = r_out_full;

        w_ram_we       = 1'b0;
        w_ram_addr     = r_pos;
        w_wslot.epoch  = r_epoch;
        w_wslot.x      = r_x;
        w_wslot.y      = r_y;
        w_wslot.z      = r_z;
        w_wslot.idx    = r_count[vdit_pkg::IDX_W-1:0];
        w_resolved     = 1'b0;
        w_idx          = '0;
        w_new          = 1'b0;
        w_full         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_vtx.valid) begin
                    n_x         = vdit_pkg::fold_zero(i_vtx.x_bits);
                    n_y         = vdit_pkg::fold_zero(i_vtx.y_bits);
                    n_z         = vdit_pkg::fold_zero(i_vtx.z_bits);
                    n_have_item = 1'b1;
                    n_state     = S_HASH;
                    if (i_vtx.new_mesh) begin
                        n_count = '0;
                        if (r_epoch == vdit_pkg::EPOCH_LAST) begin
                            // epoch tags run out: wipe every slot first
                            n_epoch    = vdit_pkg::EPOCH_FIRST;
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end else begin
                            n_epoch = r_epoch + 1'b1;
                        end
                    end
                end
            end
            S_CLEAR: begin
                w_ram_we      = 1'b1;
                w_ram_addr    = r_clr_addr;
                w_wslot.epoch = vdit_pkg::EPOCH_NONE;
                if (r_clr_addr == SLOT_LAST) begin
                    n_state = r_have_item ? S_HASH : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_HASH: begin
                n_state = S_ADDR;
            end
            S_ADDR: begin
                w_ram_addr = w_hash_slot;
                n_pos      = w_hash_slot;
                n_probe    = '0;
                n_state    = S_PROBE;
            end
            S_PROBE: begin
                if (!w_live) begin
                    w_resolved = 1'b1;
                    if (r_count >= COUNT_MAX) begin
                        w_full = 1'b1;
                    end else begin
                        w_ram_we = 1'b1;
                        w_idx    = r_count[vdit_pkg::IDX_W-1:0];
                        w_new    = 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                end else if (w_key_eq) begin
                    w_resolved = 1'b1;
                    w_idx      = w_rslot.idx;
                end else if (r_probe == SLOT_LAST) begin
                    // wrapped over every slot with no free one
                    w_resolved = 1'b1;
                    w_full     = 1'b1;
                end else begin
                    w_ram_addr = w_next_pos;
                    n_pos      = w_next_pos;
                    n_probe    = r_probe + 1'b1;
                end
                if (w_resolved) begin
                    n_res_idx  = w_idx;
                    n_res_new  = w_new;
                    n_res_full = w_full;
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_idx   = w_idx;
                        n_out_new   = w_new;
                        n_out_full  = w_full;
                        n_have_item = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_res_idx;
                    n_out_new   = r_res_new;
                    n_out_full  = r_res_full;
                    n_have_item = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_epoch     <= vdit_pkg::EPOCH_FIRST;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_have_item <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_epoch     <= n_epoch;
            r_count     <= n_count;
            r_clr_addr  <= n_clr_addr;
            r_have_item <= n_have_item;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_pos      <= n_pos;
        r_probe    <= n_probe;
        r_res_idx  <= n_res_idx;
        r_res_new  <= n_res_new;
        r_res_full <= n_res_full;
        r_out_idx  <= n_out_idx;
        r_out_new  <= n_out_new;
        r_out_full <= n_out_full;
    end

endmodule

`default_nettype wire

@@ test/vertex_dedup_index_table_tb.sv @@
// testbench for the vertex dedup index table: directed welding cases, random meshes, dense runs, mesh restarts
`timescale 1ns / 1ps

module vertex_dedup_index_table_tb;

    typedef struct packed {
        logic [vdit_pkg::COORD_W-1:0] x;
        logic [vdit_pkg::COORD_W-1:0] y;
        logic [vdit_pkg::COORD_W-1:0] z;
    } t_coord3;

    typedef struct packed {
        logic [vdit_pkg::IDX_W-1:0] idx;
        logic                       is_new;
        logic                       full;
    } t_vertex_result;

    logic i_clk;
    logic i_rst_n;

    vdit_in_if  vtx();
    vdit_out_if res();

    vertex_dedup_index_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx),
        .o_res   (res)
    );

    // predictor copy of the hash table
    bit                           slot_used [vdit_pkg::TABLE_SLOTS];
    logic [vdit_pkg::COORD_W-1:0] slot_xc [vdit_pkg::TABLE_SLOTS];
    logic [vdit_pkg::COORD_W-1:0] slot_yc [vdit_pkg::TABLE_SLOTS];
    logic [vdit_pkg::COORD_W-1:0] slot_zc [vdit_pkg::TABLE_SLOTS];
    logic [vdit_pkg::IDX_W-1:0]   slot_idx [vdit_pkg::TABLE_SLOTS];
    int unsigned                  welded_count;

    t_vertex_result expected_results [$];
    t_vertex_result want;
    t_coord3        seen_pool [$];
    int unsigned    error_count;
    bit             steady_flow;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void clear_mesh();
        for (int i = 0; i < vdit_pkg::TABLE_SLOTS; i++) slot_used[i] = 1'b0;
        welded_count = 0;
    endfunction

    function automatic t_vertex_result weld_vertex(input t_coord3 v, input logic nm);
        logic [vdit_pkg::COORD_W-1:0] x;
        logic [vdit_pkg::COORD_W-1:0] y;
        logic [vdit_pkg::COORD_W-1:0] z;
        logic [vdit_pkg::COORD_W-1:0] h;
        logic [vdit_pkg::SLOT_AW-1:0] pos;
        bit                           have_free;
        t_vertex_result               r;
        x = (v.x == vdit_pkg::NEG_ZERO) ? '0 : v.x;
        y = (v.y == vdit_pkg::NEG_ZERO) ? '0 : v.y;
        z = (v.z == vdit_pkg::NEG_ZERO) ? '0 : v.z;
        have_free = 1'b0;
        if (nm) clear_mesh();
        h = (x * vdit_pkg::HASH_KX) ^ (y * vdit_pkg::HASH_KY) ^ (z * vdit_pkg::HASH_KZ);
        h = h ^ (h >> 16);
        pos = h[vdit_pkg::SLOT_AW-1:0];
        for (int n = 0; n < vdit_pkg::TABLE_SLOTS; n++) begin
            if (!slot_used[pos]) begin
                have_free = 1'b1;
                break;
            end
            if (slot_xc[pos] == x && slot_yc[pos] == y && slot_zc[pos] == z) begin
                r.idx = slot_idx[pos];
                r.is_new = 1'b0;
                r.full = 1'b0;
                return r;
            end
            pos = pos + 1'b1;
        end
        if (!have_free || welded_count >= vdit_pkg::MAX_VERTICES) begin
            r.idx = '0;
            r.is_new = 1'b0;
            r.full = 1'b1;
            return r;
        end
        slot_used[pos] = 1'b1;
        slot_xc[pos] = x;
        slot_yc[pos] = y;
        slot_zc[pos] = z;
        slot_idx[pos] = vdit_pkg::IDX_W'(welded_count);
        r.idx = vdit_pkg::IDX_W'(welded_count);
        r.is_new = 1'b1;
        r.full = 1'b0;
        welded_count++;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned got_v);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
        error_count++;
    endtask

    // one vertex transfer; the prediction is made at the accepting edge
    task automatic send_vertex(input t_coord3 v, input logic nm);
        @(negedge i_clk);
        if (!steady_flow && $urandom_range(99) < 10) begin
            vtx.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        vtx.valid    <= 1'b1;
        vtx.x_bits   <= v.x;
        vtx.y_bits   <= v.y;
        vtx.z_bits   <= v.z;
        vtx.new_mesh <= nm;
        do @(posedge i_clk); while (!vtx.ready);
        expected_results.push_back(weld_vertex(v, nm));
        seen_pool.push_back(v);
        if (seen_pool.size() > 64) void'(seen_pool.pop_front());
    endtask

    always @(negedge i_clk) begin
        res.ready <= steady_flow || ($urandom_range(99) >= 10);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", 0, 32'(res.vertex_index));
            end else begin
                want = expected_results.pop_front();
                if (res.vertex_index !== want.idx)
                    report_mismatch("vertex_index", 32'(want.idx), 32'(res.vertex_index));
                if (res.is_new !== want.is_new)
                    report_mismatch("is_new", 32'(want.is_new), 32'(res.is_new));
                if (res.table_full !== want.full)
                    report_mismatch("table_full", 32'(want.full), 32'(res.table_full));
            end
        end
    end

    function automatic t_coord3 mk(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z);
        t_coord3 v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    function automatic logic [vdit_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(19))
            0: return 32'h0000_0000;
            1: return vdit_pkg::NEG_ZERO;
            2: return 32'h7F80_0000;
            3: return 32'hFF80_0000;
            4: return 32'h7FC0_0000;
            5: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // zero signs, infinities, nans, extremes and mesh restarts
    task automatic test_directed_welding();
        send_vertex(mk(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000), 1'b1);
        send_vertex(mk(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000), 1'b0);
        send_vertex(mk(32'h0000_0000, 32'h0000_0000, 32'h0000_0000), 1'b0);
        send_vertex(mk(vdit_pkg::NEG_ZERO, 32'h0000_0000, 32'h0000_0000), 1'b0);
        send_vertex(mk(32'h0000_0000, vdit_pkg::NEG_ZERO, 32'h0000_0000), 1'b0);
        send_vertex(mk(32'h0000_0000, 32'h0000_0000, vdit_pkg::NEG_ZERO), 1'b0);
        send_vertex(mk(vdit_pkg::NEG_ZERO, vdit_pkg::NEG_ZERO, vdit_pkg::NEG_ZERO), 1'b0);
        send_vertex(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
        send_vertex(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
        send_vertex(mk(32'h7FC0_0000, 32'h7FC0_0001, 32'h7FC0_0000), 1'b0);
        send_vertex(mk(32'h7FC0_0000, 32'h7FC0_0001, 32'h7FC0_0000), 1'b0);
        send_vertex(mk(32'h7F80_0000, 32'hFF80_0000, 32'h0000_0001), 1'b0);
        send_vertex(mk(32'hFF80_0000, 32'h7F80_0000, 32'h0000_0001), 1'b0);
        send_vertex(mk(32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFF), 1'b0);
        send_vertex(mk(32'h7F80_0000, 32'hFF80_0000, 32'h0000_0001), 1'b0);
        // the first vertex after a restart gets index zero
        send_vertex(mk(32'h0000_0000, 32'h0000_0000, 32'h0000_0000), 1'b1);
        send_vertex(mk(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000), 1'b0);
        send_vertex(mk(vdit_pkg::NEG_ZERO, 32'h0000_0000, vdit_pkg::NEG_ZERO), 1'b0);
        send_vertex(mk(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000), 1'b1);
        send_vertex(mk(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000), 1'b0);
    endtask

    // long run of distinct vertices with no idling, then look up stored ones
    task automatic test_dense_run();
        t_coord3 kept [$];
        t_coord3 v;
        steady_flow = 1'b1;
        for (int i = 0; i < 80; i++) begin
            v = mk({20'($urandom), 12'(i)}, $urandom, $urandom);
            if (i % 16 == 7) kept.push_back(v);
            send_vertex(v, i == 0);
        end
        steady_flow = 1'b0;
        foreach (kept[i]) send_vertex(kept[i], 1'b0);
        send_vertex(kept[0], 1'b1);
        send_vertex(kept[1], 1'b0);
        send_vertex(kept[0], 1'b0);
    endtask

    // enough restarts to run through every epoch tag and the wipe that follows
    task automatic test_mesh_restarts();
        t_coord3 v;
        for (int i = 0; i < 16; i++) begin
            v = mk(pick_coord(), pick_coord(), pick_coord());
            send_vertex(v, 1'b1);
            send_vertex(v, 1'b0);
        end
    endtask

    // mostly repeats and near misses of recent vertices, some fresh ones, rare restarts
    task automatic test_random_mesh(input int count);
        t_coord3 v;
        int      pick;
        logic    nm;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            nm = ($urandom_range(99) < 3);
            if (pick < 45 && seen_pool.size() > 0) begin
                v = seen_pool[$urandom_range(seen_pool.size() - 1)];
                // flip the sign of a zero coordinate now and then
                if (v.x == '0 && $urandom_range(1)) v.x = vdit_pkg::NEG_ZERO;
                if (v.y == vdit_pkg::NEG_ZERO && $urandom_range(1)) v.y = '0;
            end else if (pick < 65 && seen_pool.size() > 0) begin
                v = seen_pool[$urandom_range(seen_pool.size() - 1)];
                case ($urandom_range(2))
                    0: v.x = pick_coord();
                    1: v.y = pick_coord();
                    default: v.z = pick_coord();
                endcase
            end else begin
                v = mk(pick_coord(), pick_coord(), pick_coord());
            end
            send_vertex(v, nm);
        end
    endtask

    initial begin
        vtx.valid    = 1'b0;
        vtx.x_bits   = '0;
        vtx.y_bits   = '0;
        vtx.z_bits   = '0;
        vtx.new_mesh = 1'b0;
        res.ready    = 1'b0;
        error_count  = 0;
        steady_flow  = 1'b0;
        clear_mesh();
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_welding();
        test_random_mesh(170);
        test_dense_run();
        test_mesh_restarts();
        test_random_mesh(110);

        @(negedge i_clk);
        vtx.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ vertex_dedup_index_table.f @@
hw/rtl/vdit_pkg.sv
hw/rtl/vdit_in_if.sv
hw/rtl/vdit_out_if.sv
hw/rtl/vdit_ram.sv
hw/rtl/vdit_hash.sv
hw/rtl/vertex_dedup_index_table.sv
test/vertex_dedup_index_table_tb.sv
